FILE: design/ckbc_pkg.sv
// ----------------------------------------------------------------------------
// ckbc_pkg
// Shared types and constants of the color key blit clipper.
// ----------------------------------------------------------------------------
package ckbc_pkg;

	localparam int DIM_W           = 11;
	localparam int COORD_W         = 10;
	localparam int OFFSET_W        = 22;
	localparam int COLOR_W         = 8;
	localparam int MAX_DIMENSION   = 1024;
	localparam int BYTES_PER_PIXEL = 3;
	localparam int QUEUE_DEPTH     = 4;
	localparam int PROD_W          = 21;
	localparam int S_TDATA_W       = 88;
	localparam int M_TDATA_W       = 96;
	localparam int CFG_INDEX_W     = 2;

	localparam logic [DIM_W-1:0]   DIM_RESET = DIM_W'(1024);
	localparam logic [DIM_W-1:0]   DIM_MAX   = DIM_W'(MAX_DIMENSION);
	localparam logic [COLOR_W-1:0] KEY_LEVEL = 8'hFF;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd3;

	typedef enum logic {
		OP_START = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STATUS_START_OK  = 3'd0,
		STATUS_START_REJ = 3'd1,
		STATUS_WRITTEN   = 3'd2,
		STATUS_KEYED     = 3'd3,
		STATUS_IDLE_PIX  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_START_OK  = 2'd0,
		KIND_START_REJ = 2'd1,
		KIND_PIXEL     = 2'd2
	} kind_t;

	typedef struct packed {
		logic [DIM_W-1:0] tw;
		logic [DIM_W-1:0] th;
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
	} dims_t;

	typedef struct packed {
		op_t                operation;
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [COORD_W-1:0] src_x;
		logic [COORD_W-1:0] src_y;
		logic [DIM_W-1:0]   rect_width;
		logic [DIM_W-1:0]   rect_height;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} item_t;

	typedef struct packed {
		kind_t               kind;
		logic [DIM_W-1:0]    clip_w;
		logic [DIM_W-1:0]    clip_h;
		logic [OFFSET_W-1:0] src_off;
		logic [OFFSET_W-1:0] dst_off;
		logic [COLOR_W-1:0]  red;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  blue;
	} entry_t;

	function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
			input logic [DIM_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

FILE: design/color_key_blit_clipper_core.sv
// ----------------------------------------------------------------------------
// color_key_blit_clipper_core
// 24-bit RGB blit engine with clipping and a white color key.
// ----------------------------------------------------------------------------
// usage:
//  - configuration: cfg_we/cfg_index/cfg_data write target and source image
//    sizes (0 target width, 1 target height, 2 source width, 3 source height);
//    write them only while no transaction is in flight
//  - input stream (s_*): s_tuser selects a start (0) or a pixel (1); a start
//    carries the corners and the requested size, a pixel carries its bytes
//  - output stream (m_*): exactly one result transaction per input
//    transaction, in order; m_tuser is the status, m_tlast marks the final
//    pixel of the clipped rectangle
//  - path: with an empty queue an accepted transaction goes from the front
//    stage register to the queue write, then to the result register
//  - throughput: one transaction per cycle while the receiver takes results;
//    the blit counters in the back end step one pixel per pixel of a blit
//  - reset clears the pipeline, the queue and the blit state, and sets all
//    four image sizes to 1024
//  - when the receiver stalls the result register holds, the queue fills,
//    and s_tready drops once the queue and the front stage are full
// ----------------------------------------------------------------------------
module color_key_blit_clipper_core #(
	parameter int QUEUE_DEPTH = ckbc_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [ckbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ckbc_pkg::DIM_W-1:0]         cfg_data,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// dest_x, dest_y, src_x, src_y, rect_width, rect_height, red, green, blue
	input  logic [ckbc_pkg::S_TDATA_W-1:0]     s_tdata,
	// operation
	input  logic                               s_tuser,
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// clipped_width, clipped_height, source_offset, dest_offset,
	// write_enable, out_red, out_green, out_blue
	output logic [ckbc_pkg::M_TDATA_W-1:0]     m_tdata,
	// status
	output logic [2:0]                         m_tuser,
	// last
	output logic                               m_tlast
);
	import ckbc_pkg::*;

	logic [DIM_W-1:0] tw_q;
	logic [DIM_W-1:0] th_q;
	logic [DIM_W-1:0] sw_q;
	logic [DIM_W-1:0] sh_q;
	dims_t            dims;
	item_t            item;
	logic             fq_valid;
	logic             fq_ready;
	entry_t           fq_entry;
	logic             qb_valid;
	logic             qb_ready;
	entry_t           qb_entry;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= DIM_RESET;
			th_q <= DIM_RESET;
			sw_q <= DIM_RESET;
			sh_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_WIDTH:  tw_q <= cfg_data;
				REG_TARGET_HEIGHT: th_q <= cfg_data;
				REG_SOURCE_WIDTH:  sw_q <= cfg_data;
				REG_SOURCE_HEIGHT: sh_q <= cfg_data;
				default:           tw_q <= tw_q;
			endcase
		end
	end

	// sizes above the maximum dimension act as the maximum
	always_comb begin
		dims.tw = min_dim(tw_q, DIM_MAX);
		dims.th = min_dim(th_q, DIM_MAX);
		dims.sw = min_dim(sw_q, DIM_MAX);
		dims.sh = min_dim(sh_q, DIM_MAX);
	end

	// unpack the input transaction
	always_comb begin
		item.operation   = op_t'(s_tuser);
		item.dest_x      = s_tdata[9:0];
		item.dest_y      = s_tdata[19:10];
		item.src_x       = s_tdata[29:20];
		item.src_y       = s_tdata[39:30];
		item.rect_width  = s_tdata[50:40];
		item.rect_height = s_tdata[61:51];
		item.red         = s_tdata[69:62];
		item.green       = s_tdata[77:70];
		item.blue        = s_tdata[85:78];
	end

	// front: classify, check and clip starts, corner offsets
	ckbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.dims     (dims),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.item     (item),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_entry  (fq_entry)
	);

	// decoupling queue so either side can stall alone
	ckbc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_entry (fq_entry),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_entry (qb_entry)
	);

	// back: blit state, per-pixel offsets and key test, result register
	ckbc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.target_width (dims.tw),
		.q_valid      (qb_valid),
		.q_ready      (qb_ready),
		.q_entry      (qb_entry),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

endmodule

FILE: design/ckbc_front.sv
// ----------------------------------------------------------------------------
// ckbc_front
// Classifies items, checks and clips starts, computes corner byte offsets.
// ----------------------------------------------------------------------------
module ckbc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  ckbc_pkg::dims_t dims,
	input  logic            in_valid,
	output logic            in_ready,
	input  ckbc_pkg::item_t item,
	output logic            q_valid,
	input  logic            q_ready,
	output ckbc_pkg::entry_t q_entry
);
	import ckbc_pkg::*;

	logic                valid_s1;
	kind_t               kind_s1;
	logic [DIM_W-1:0]    clip_w_s1;
	logic [DIM_W-1:0]    clip_h_s1;
	logic [COORD_W-1:0]  dx_s1;
	logic [COORD_W-1:0]  sx_s1;
	logic [PROD_W-1:0]   pd_s1;
	logic [PROD_W-1:0]   ps_s1;
	logic [COLOR_W-1:0]  red_s1;
	logic [COLOR_W-1:0]  green_s1;
	logic [COLOR_W-1:0]  blue_s1;

	logic                reject;
	kind_t               kind;
	logic [DIM_W-1:0]    clip_w;
	logic [DIM_W-1:0]    clip_h;
	logic [PROD_W-1:0]   prod_d;
	logic [PROD_W-1:0]   prod_s;
	logic [OFFSET_W-1:0] dst_base;
	logic [OFFSET_W-1:0] src_base;
	logic                advance;

	assign advance  = !valid_s1 || q_ready;
	assign in_ready = advance;

	always_comb begin
		reject = ({1'b0, item.dest_x} >= dims.tw) || ({1'b0, item.dest_y} >= dims.th) ||
			({1'b0, item.src_x} >= dims.sw) || ({1'b0, item.src_y} >= dims.sh) ||
			(item.rect_width == '0) || (item.rect_height == '0);
		clip_w = min_dim(min_dim(item.rect_width, dims.tw - {1'b0, item.dest_x}),
			dims.sw - {1'b0, item.src_x});
		clip_h = min_dim(min_dim(item.rect_height, dims.th - {1'b0, item.dest_y}),
			dims.sh - {1'b0, item.src_y});
		prod_d = PROD_W'(item.dest_y) * PROD_W'(dims.tw);
		prod_s = PROD_W'(item.src_y) * PROD_W'(dims.sw);
		if (item.operation == OP_PIXEL) begin
			kind = KIND_PIXEL;
		end else if (reject) begin
			kind = KIND_START_REJ;
		end else begin
			kind = KIND_START_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			kind_s1   <= kind;
			clip_w_s1 <= clip_w;
			clip_h_s1 <= clip_h;
			dx_s1     <= item.dest_x;
			sx_s1     <= item.src_x;
			pd_s1     <= prod_d;
			ps_s1     <= prod_s;
			red_s1    <= item.red;
			green_s1  <= item.green;
			blue_s1   <= item.blue;
		end
	end

	// row product plus column, then three bytes per pixel, wrapped to 22 bits
	assign dst_base = OFFSET_W'(pd_s1) + OFFSET_W'(dx_s1);
	assign src_base = OFFSET_W'(ps_s1) + OFFSET_W'(sx_s1);

	always_comb begin
		q_entry.kind    = kind_s1;
		q_entry.clip_w  = clip_w_s1;
		q_entry.clip_h  = clip_h_s1;
		q_entry.dst_off = OFFSET_W'(dst_base * BYTES_PER_PIXEL);
		q_entry.src_off = OFFSET_W'(src_base * BYTES_PER_PIXEL);
		q_entry.red     = red_s1;
		q_entry.green   = green_s1;
		q_entry.blue    = blue_s1;
	end

	assign q_valid = valid_s1;

endmodule

FILE: design/ckbc_queue.sv
// ----------------------------------------------------------------------------
// ckbc_queue
// Short first-in first-out queue of classified items.
// ----------------------------------------------------------------------------
module ckbc_queue #(
	parameter int DEPTH = ckbc_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  ckbc_pkg::entry_t wr_entry,
	output logic             rd_valid,
	input  logic             rd_ready,
	output ckbc_pkg::entry_t rd_entry
);
	import ckbc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

FILE: design/ckbc_back.sv
// ----------------------------------------------------------------------------
// ckbc_back
// Runs the blit: raster counters, target offsets, color key, result register.
// ----------------------------------------------------------------------------
module ckbc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ckbc_pkg::DIM_W-1:0]      target_width,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  ckbc_pkg::entry_t                q_entry,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ckbc_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast
);
	import ckbc_pkg::*;

	logic                active_q;
	logic [DIM_W-1:0]    run_w_q;
	logic [DIM_W-1:0]    run_h_q;
	logic [DIM_W-1:0]    col_q;
	logic [DIM_W-1:0]    row_q;
	logic [OFFSET_W-1:0] row_off_q;
	logic [OFFSET_W-1:0] pix_off_q;

	logic                out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	status_t             out_status_q;
	logic                out_last_q;

	logic                pop;
	logic [DIM_W:0]      col_inc;
	logic [DIM_W:0]      row_inc;
	logic                row_end;
	logic                is_last;
	logic                key;
	logic [OFFSET_W-1:0] row_step;
	status_t             status;
	logic [DIM_W-1:0]    res_cw;
	logic [DIM_W-1:0]    res_ch;
	logic [OFFSET_W-1:0] res_soff;
	logic [OFFSET_W-1:0] res_doff;
	logic                res_we;
	logic [COLOR_W-1:0]  res_r;
	logic [COLOR_W-1:0]  res_g;
	logic [COLOR_W-1:0]  res_b;
	logic                res_last;

	assign pop     = q_valid && (!out_valid_q || m_tready);
	assign q_ready = !out_valid_q || m_tready;

	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign row_end  = (col_inc >= {1'b0, run_w_q});
	assign is_last  = row_end && (row_inc >= {1'b0, run_h_q});
	assign key      = (q_entry.red == KEY_LEVEL) && (q_entry.green == KEY_LEVEL) &&
		(q_entry.blue == KEY_LEVEL);
	assign row_step = OFFSET_W'(target_width * BYTES_PER_PIXEL);

	always_comb begin
		status   = STATUS_IDLE_PIX;
		res_cw   = '0;
		res_ch   = '0;
		res_soff = '0;
		res_doff = '0;
		res_we   = 1'b0;
		res_r    = '0;
		res_g    = '0;
		res_b    = '0;
		res_last = 1'b0;
		case (q_entry.kind)
			KIND_START_OK: begin
				status   = STATUS_START_OK;
				res_cw   = q_entry.clip_w;
				res_ch   = q_entry.clip_h;
				res_soff = q_entry.src_off;
			end
			KIND_START_REJ: begin
				status = STATUS_START_REJ;
			end
			KIND_PIXEL: begin
				if (active_q) begin
					status   = key ? STATUS_KEYED : STATUS_WRITTEN;
					res_doff = pix_off_q;
					res_we   = !key;
					res_r    = key ? '0 : q_entry.red;
					res_g    = key ? '0 : q_entry.green;
					res_b    = key ? '0 : q_entry.blue;
					res_last = is_last;
				end
			end
			default: begin
				status = STATUS_IDLE_PIX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			run_w_q     <= '0;
			run_h_q     <= '0;
			col_q       <= '0;
			row_q       <= '0;
			row_off_q   <= '0;
			pix_off_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (q_entry.kind)
					KIND_START_OK: begin
						active_q  <= 1'b1;
						run_w_q   <= q_entry.clip_w;
						run_h_q   <= q_entry.clip_h;
						col_q     <= '0;
						row_q     <= '0;
						row_off_q <= q_entry.dst_off;
						pix_off_q <= q_entry.dst_off;
					end
					KIND_START_REJ: begin
						active_q <= 1'b0;
					end
					KIND_PIXEL: begin
						if (active_q) begin
							if (is_last) begin
								active_q <= 1'b0;
								col_q    <= '0;
								row_q    <= '0;
							end else if (row_end) begin
								col_q     <= '0;
								row_q     <= row_inc[DIM_W-1:0];
								row_off_q <= row_off_q + row_step;
								pix_off_q <= row_off_q + row_step;
							end else begin
								col_q     <= col_inc[DIM_W-1:0];
								pix_off_q <= pix_off_q + OFFSET_W'(BYTES_PER_PIXEL);
							end
						end
					end
					default: begin
						active_q <= active_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_status_q <= status;
			out_last_q   <= res_last;
			out_data_q   <= {5'b0, res_b, res_g, res_r, res_we, res_doff, res_soff,
				res_ch, res_cw};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule
